// File: hw/rtl/sgb_pkg.sv
// Shared types and constants for the segment glow blend pipeline.
package sgb_pkg;

  localparam int COORD_W  = 8;
  localparam int CHAN_W   = 8;
  localparam int WIDTH_W  = 9;
  localparam int ENERGY_W = 16;
  localparam int DSQ_W    = 17;
  localparam int PROD_W   = ENERGY_W + CHAN_W;
  localparam int DIV_CELLS = ENERGY_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [ENERGY_W-1:0] ONE_Q88       = 16'd256;
  localparam logic [CHAN_W-1:0]   CHAN_MAX      = 8'd255;
  localparam logic [ENERGY_W-1:0] ENERGY_RESET  = 16'd2560;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEG_START_COL = 3'd0,
    CFG_SEG_ROW       = 3'd1,
    CFG_SEG_WIDTH     = 3'd2,
    CFG_GLOW_RED      = 3'd3,
    CFG_GLOW_GREEN    = 3'd4,
    CFG_GLOW_BLUE     = 3'd5,
    CFG_GLOW_ENERGY   = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] pix_col;
    logic [COORD_W-1:0] pix_row;
    logic [CHAN_W-1:0]  in_red;
    logic [CHAN_W-1:0]  in_green;
    logic [CHAN_W-1:0]  in_blue;
  } in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
  } out_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  // One word travelling down the divider chain.
  typedef struct packed {
    logic [DSQ_W-1:0]    rem;
    logic [ENERGY_W-1:0] dvd;
    logic [ENERGY_W-1:0] quo;
    logic [DSQ_W-1:0]    dsr;
    logic                zero;
    rgb_t                pix;
  } div_word_t;

endpackage

// File: hw/rtl/segment_glow_blend.sv
// Top level: config registers, front stages, divider cell chain and blend.
//
//   channel  direction  handshake          payload
//   in_      sink       in_valid/in_stall  in_t   (pix_col, pix_row, in_red..in_blue)
//   out_     source     out_valid/out_stall out_t (out_red, out_green, out_blue)
//   cfg_     sink       cfg_valid/cfg_ready cfg_index (3 bit), cfg_data (16 bit)
//
// One pixel per clock sustained while out_stall is low. The result word passes through
// two front stages, sixteen divider cells (one quotient bit each) and two blend
// stages.
// Synchronous active-low reset clears all valid bits and loads register defaults.
// Each stage holds its word only while it is full and its successor stalls, so
// bubbles are squeezed out and the input keeps flowing behind a stalled output
// until every stage is full.
module segment_glow_blend import sgb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [COORD_W-1:0]  seg_start_col_r;
  logic [COORD_W-1:0]  seg_row_r;
  logic [WIDTH_W-1:0]  seg_width_r;
  logic [CHAN_W-1:0]   glow_red_r;
  logic [CHAN_W-1:0]   glow_green_r;
  logic [CHAN_W-1:0]   glow_blue_r;
  logic [ENERGY_W-1:0] glow_energy_r;

  div_word_t div_w [DIV_CELLS+1];
  logic      div_v [DIV_CELLS+1];
  logic      div_s [DIV_CELLS+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_start_col_r <= '0;
      seg_row_r       <= '0;
      seg_width_r     <= '0;
      glow_red_r      <= '0;
      glow_green_r    <= '0;
      glow_blue_r     <= '0;
      glow_energy_r   <= ENERGY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SEG_START_COL: seg_start_col_r <= cfg_data[COORD_W-1:0];
        CFG_SEG_ROW:       seg_row_r       <= cfg_data[COORD_W-1:0];
        CFG_SEG_WIDTH:     seg_width_r     <= cfg_data[WIDTH_W-1:0];
        CFG_GLOW_RED:      glow_red_r      <= cfg_data[CHAN_W-1:0];
        CFG_GLOW_GREEN:    glow_green_r    <= cfg_data[CHAN_W-1:0];
        CFG_GLOW_BLUE:     glow_blue_r     <= cfg_data[CHAN_W-1:0];
        CFG_GLOW_ENERGY:   glow_energy_r   <= cfg_data[ENERGY_W-1:0];
        default: ;
      endcase
    end
  end

  sgb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .seg_start_col (seg_start_col_r),
    .seg_row       (seg_row_r),
    .seg_width     (seg_width_r),
    .glow_energy   (glow_energy_r),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_data),
    .out_valid     (div_v[0]),
    .out_stall     (div_s[0]),
    .out_word      (div_w[0])
  );

  for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
    sgb_div_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (div_v[i]),
      .in_stall  (div_s[i]),
      .in_word   (div_w[i]),
      .out_valid (div_v[i+1]),
      .out_stall (div_s[i+1]),
      .out_word  (div_w[i+1])
    );
  end

  sgb_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .glow_red   (glow_red_r),
    .glow_green (glow_green_r),
    .glow_blue  (glow_blue_r),
    .in_valid   (div_v[DIV_CELLS]),
    .in_stall   (div_s[DIV_CELLS]),
    .in_word    (div_w[DIV_CELLS]),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// File: hw/rtl/sgb_front.sv
// Distance and squared-distance stages ahead of the divider chain.
module sgb_front import sgb_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [COORD_W-1:0]  seg_start_col,
  input  logic [COORD_W-1:0]  seg_row,
  input  logic [WIDTH_W-1:0]  seg_width,
  input  logic [ENERGY_W-1:0] glow_energy,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_t                 in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output div_word_t           out_word
);

  logic                   va_r;
  logic [COORD_W-1:0]     dx_r, dx_nxt;
  logic [COORD_W-1:0]     dy_r, dy_nxt;
  rgb_t                   pa_r;
  logic                   vb_r;
  div_word_t              wb_r, wb_nxt;
  logic                   stall_a, stall_b;
  logic [WIDTH_W:0]       seg_end;
  logic [WIDTH_W:0]       col_ext;
  logic [2*COORD_W-1:0]   sq_x, sq_y;

  assign stall_b  = vb_r & out_stall;
  assign stall_a  = va_r & stall_b;
  assign in_stall = stall_a;

  // The segment end is kept wide so a span past the image has no right side.
  assign seg_end = {2'b00, seg_start_col} + {1'b0, seg_width};
  assign col_ext = {2'b00, in_word.pix_col};

  always_comb begin
    if (in_word.pix_col < seg_start_col) begin
      dx_nxt = seg_start_col - in_word.pix_col;
    end else if (col_ext >= seg_end) begin
      dx_nxt = COORD_W'(col_ext - seg_end);
    end else begin
      dx_nxt = '0;
    end
    if (in_word.pix_row >= seg_row) begin
      dy_nxt = in_word.pix_row - seg_row;
    end else begin
      dy_nxt = seg_row - in_word.pix_row;
    end
  end

  assign sq_x = {{COORD_W{1'b0}}, dx_r} * {{COORD_W{1'b0}}, dx_r};
  assign sq_y = {{COORD_W{1'b0}}, dy_r} * {{COORD_W{1'b0}}, dy_r};

  always_comb begin
    wb_nxt      = '0;
    wb_nxt.dsr  = {1'b0, sq_x} + {1'b0, sq_y};
    wb_nxt.zero = (dx_r == '0) && (dy_r == '0);
    wb_nxt.dvd  = glow_energy;
    wb_nxt.pix  = pa_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (!stall_a) begin
        va_r <= in_valid;
      end
      if (!stall_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall_a) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      pa_r <= '{red: in_word.in_red, green: in_word.in_green, blue: in_word.in_blue};
    end
    if (!stall_b) begin
      wb_r <= wb_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_word  = wb_r;

endmodule

// File: hw/rtl/sgb_div_cell.sv
// One restoring-division cell: resolves one quotient bit per word.
module sgb_div_cell import sgb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  div_word_t in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output div_word_t out_word
);

  logic             valid_r;
  div_word_t        word_r, word_nxt;
  logic             stall_up;
  logic [DSQ_W:0]   shifted;
  logic [DSQ_W:0]   diff;
  logic             fits;

  assign stall_up = valid_r & out_stall;
  assign in_stall = stall_up;

  assign shifted = {in_word.rem, in_word.dvd[ENERGY_W-1]};
  assign diff    = shifted - {1'b0, in_word.dsr};
  assign fits    = shifted >= {1'b0, in_word.dsr};

  always_comb begin
    word_nxt     = in_word;
    word_nxt.dvd = {in_word.dvd[ENERGY_W-2:0], 1'b0};
    if (fits) begin
      word_nxt.rem = diff[DSQ_W-1:0];
      word_nxt.quo = {in_word.quo[ENERGY_W-2:0], 1'b1};
    end else begin
      word_nxt.rem = shifted[DSQ_W-1:0];
      word_nxt.quo = {in_word.quo[ENERGY_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!stall_up) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall_up) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

  a_rem_below_dsr: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && (word_r.dsr != '0) |-> word_r.rem < word_r.dsr)
    else $error("partial remainder not below divisor");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (word_r.zero == (word_r.dsr == '0)))
    else $error("zero-distance flag disagrees with divisor");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_stall |=> valid_r && $stable(word_r))
    else $error("stalled cell dropped or changed its word");

endmodule

// File: hw/rtl/sgb_blend.sv
// Weight-times-glow products and saturating add into the output register.
module sgb_blend import sgb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [CHAN_W-1:0] glow_red,
  input  logic [CHAN_W-1:0] glow_green,
  input  logic [CHAN_W-1:0] glow_blue,
  input  logic              in_valid,
  output logic              in_stall,
  input  div_word_t         in_word,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data
);

  logic                  vp_r;
  logic [PROD_W-1:0]     prod_red_r, prod_green_r, prod_blue_r;
  rgb_t                  pix_r;
  logic                  vo_r;
  out_t                  out_r, out_nxt;
  logic [ENERGY_W-1:0]   weight;
  logic                  stall_p, stall_o;

  function automatic logic [CHAN_W-1:0] sat_add(input logic [CHAN_W-1:0] chan,
                                               input logic [PROD_W-1:0] prod);
    logic [ENERGY_W:0] sum;
    sum = {{(ENERGY_W-CHAN_W+1){1'b0}}, chan} + {1'b0, prod[PROD_W-1:CHAN_W]};
    if (sum > {{(ENERGY_W-CHAN_W+1){1'b0}}, CHAN_MAX}) begin
      return CHAN_MAX;
    end
    return sum[CHAN_W-1:0];
  endfunction

  assign stall_o  = vo_r & out_stall;
  assign stall_p  = vp_r & stall_o;
  assign in_stall = stall_p;

  // Zero distance means full weight, 1.0 in Q8.8.
  assign weight = in_word.zero ? ONE_Q88 : in_word.quo;

  always_comb begin
    out_nxt.out_red   = sat_add(pix_r.red,   prod_red_r);
    out_nxt.out_green = sat_add(pix_r.green, prod_green_r);
    out_nxt.out_blue  = sat_add(pix_r.blue,  prod_blue_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (!stall_p) begin
        vp_r <= in_valid;
      end
      if (!stall_o) begin
        vo_r <= vp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall_p) begin
      prod_red_r   <= {{CHAN_W{1'b0}}, weight} * {{ENERGY_W{1'b0}}, glow_red};
      prod_green_r <= {{CHAN_W{1'b0}}, weight} * {{ENERGY_W{1'b0}}, glow_green};
      prod_blue_r  <= {{CHAN_W{1'b0}}, weight} * {{ENERGY_W{1'b0}}, glow_blue};
      pix_r        <= in_word.pix;
    end
    if (!stall_o) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = vo_r;
  assign out_data  = out_r;

endmodule
